/* sv/hsv_to_rgb_converter_core_defines.svh */
// Assertion macros used by the checker file.
`ifndef HSV_TO_RGB_CONVERTER_CORE_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_CORE_DEFINES_SVH

// Checked on every clock edge outside reset.
`define HSVRGB_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define HSVRGB_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* sv/hsvrgb_pkg.sv */
package hsvrgb_pkg;

   // Field widths
   localparam int HueWidth  = 9;
   localparam int CompWidth = 8;
   localparam int PosWidth  = 6;   // position inside a sextant, below 60
   localparam int Sextants  = 6;

   // Percent mode constants
   localparam int PctMax      = 100;
   localparam int PctSextant  = 60;
   localparam int PctHueLimit = 360;

   // Byte mode constants
   localparam int ByteSextant  = 43;
   localparam int ByteHueLimit = 256;
   localparam int ByteSatBase  = 256;
   localparam int ByteLoShift  = 8;

   // Reciprocal multipliers, exact floors over the value ranges that reach them
   localparam int Div100Mul   = 10486;   // x / 100 for x <= 10000
   localparam int Div100Shift = 20;
   localparam int Div60Mul    = 8739;    // x / 60 for x <= 5900
   localparam int Div43Mul    = 12193;   // x / 43 for x <= 10710
   localparam int StepShift   = 19;
   localparam int PctScaleMul   = 167127; // x * 255 / 100 for x <= 100
   localparam int PctScaleShift = 16;

   typedef enum logic {
      MODE_PERCENT = 1'b0,
      MODE_BYTE    = 1'b1
   } mode_type;

   typedef enum logic [2:0] {
      SEXT_R_TO_Y = 3'd0,
      SEXT_Y_TO_G = 3'd1,
      SEXT_G_TO_C = 3'd2,
      SEXT_C_TO_B = 3'd3,
      SEXT_B_TO_M = 3'd4,
      SEXT_M_TO_R = 3'd5
   } sext_type;

   // Control that travels down the pipeline beside the data
   typedef struct packed {
      logic     valid;
      logic     in_range;
      mode_type mode;
      sext_type sext;
   } ctl_type;

endpackage

/* sv/hsvrgb_req_if.sv */
interface hsvrgb_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [hsvrgb_pkg::HueWidth-1:0]      hue;
   logic [hsvrgb_pkg::CompWidth-1:0]     saturation;
   logic [hsvrgb_pkg::CompWidth-1:0]     brightness;

   modport source (output valid, output hue, output saturation, output brightness,
                   input ready);
   modport sink   (input valid, input hue, input saturation, input brightness,
                   output ready);
endinterface

/* sv/hsvrgb_rsp_if.sv */
interface hsvrgb_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [hsvrgb_pkg::CompWidth-1:0] red;
   logic [hsvrgb_pkg::CompWidth-1:0] green;
   logic [hsvrgb_pkg::CompWidth-1:0] blue;
   logic                             in_range;

   modport source (output valid, output red, output green, output blue,
                   output in_range, input ready);
   modport sink   (input valid, input red, input green, input blue,
                   input in_range, output ready);
endinterface

/* sv/hsvrgb_levels.sv */
// Level arithmetic: min, rising, falling and value levels over six stages.
module hsvrgb_levels (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  hsvrgb_pkg::ctl_type              ctl_in,
   input  logic [hsvrgb_pkg::PosWidth-1:0]  pos_in,
   input  logic [8:0]                       sat_inv_in,
   input  logic [hsvrgb_pkg::CompWidth-1:0] val_in,
   output hsvrgb_pkg::ctl_type              ctl_out,
   output logic [hsvrgb_pkg::CompWidth-1:0] lo_out,
   output logic [hsvrgb_pkg::CompWidth-1:0] up_out,
   output logic [hsvrgb_pkg::CompWidth-1:0] dn_out,
   output logic [hsvrgb_pkg::CompWidth-1:0] val_out
);

   localparam int CW = hsvrgb_pkg::CompWidth;
   localparam int PW = hsvrgb_pkg::PosWidth;

   // Control per stage: index 0 is the product stage, 5 the scaled levels
   hsvrgb_pkg::ctl_type ctl_ff [6];

   // Stage A: (100 - S) * V or (256 - S) * V
   logic [16:0]   p1_ff;
   logic [PW-1:0] pos_a_ff;
   logic [CW-1:0] val_a_ff;
   // Stage B: lo
   logic [CW-1:0] lo_b_ff, val_b_ff;
   logic [PW-1:0] pos_b_ff;
   // Stage C: (V - lo) * pos
   logic [13:0]   p2_ff;
   logic [CW-1:0] lo_c_ff, val_c_ff;
   // Stage D: step
   logic [CW-1:0] step_ff, lo_d_ff, val_d_ff;
   // Stage E: levels before rescale
   logic [CW-1:0] lo_e_ff, up_e_ff, dn_e_ff, val_e_ff;
   // Stage F: levels after rescale
   logic [CW-1:0] lo_f_ff, up_f_ff, dn_f_ff, val_f_ff;

   logic [30:0] lo_prod;
   logic [CW-1:0] lo_in;
   logic [CW-1:0] diff;
   logic [13:0] step_mul;
   logic [27:0] step_prod;
   logic [CW-1:0] step_in;
   logic [CW-1:0] up_in, dn_in;
   logic [25:0] sc_lo, sc_up, sc_dn, sc_val;
   logic        pct_f;

   // Divide the first product: shift in byte mode, reciprocal by 100 in percent
   assign lo_prod = 31'(p1_ff) * 31'(hsvrgb_pkg::Div100Mul);
   assign lo_in   = (ctl_ff[0].mode == hsvrgb_pkg::MODE_BYTE)
                    ? p1_ff[hsvrgb_pkg::ByteLoShift +: CW]
                    : lo_prod[hsvrgb_pkg::Div100Shift +: CW];

   assign diff = val_b_ff - lo_b_ff;

   // Step: divide by the sextant width
   assign step_mul  = (ctl_ff[2].mode == hsvrgb_pkg::MODE_BYTE)
                      ? 14'(hsvrgb_pkg::Div43Mul) : 14'(hsvrgb_pkg::Div60Mul);
   assign step_prod = 28'(p2_ff) * 28'(step_mul);
   assign step_in   = step_prod[hsvrgb_pkg::StepShift +: CW];

   assign up_in = lo_d_ff + step_ff;
   assign dn_in = val_d_ff - step_ff;

   // Rescale percent levels to bytes
   assign sc_lo  = 26'(lo_e_ff)  * 26'(hsvrgb_pkg::PctScaleMul);
   assign sc_up  = 26'(up_e_ff)  * 26'(hsvrgb_pkg::PctScaleMul);
   assign sc_dn  = 26'(dn_e_ff)  * 26'(hsvrgb_pkg::PctScaleMul);
   assign sc_val = 26'(val_e_ff) * 26'(hsvrgb_pkg::PctScaleMul);
   assign pct_f  = (ctl_ff[4].mode == hsvrgb_pkg::MODE_PERCENT);

   // Control and valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            ctl_ff[i] <= '0;
         end
      end else if (advance) begin
         ctl_ff[0] <= ctl_in;
         for (int i = 1; i < 6; i++) begin
            ctl_ff[i] <= ctl_ff[i-1];
         end
      end
   end

   // Data path
   always_ff @(posedge clock) begin
      if (advance) begin
         p1_ff    <= 17'(sat_inv_in) * 17'(val_in);
         pos_a_ff <= pos_in;
         val_a_ff <= val_in;

         lo_b_ff  <= lo_in;
         val_b_ff <= val_a_ff;
         pos_b_ff <= pos_a_ff;

         p2_ff    <= 14'(diff) * 14'(pos_b_ff);
         lo_c_ff  <= lo_b_ff;
         val_c_ff <= val_b_ff;

         step_ff  <= step_in;
         lo_d_ff  <= lo_c_ff;
         val_d_ff <= val_c_ff;

         lo_e_ff  <= lo_d_ff;
         up_e_ff  <= up_in;
         dn_e_ff  <= dn_in;
         val_e_ff <= val_d_ff;

         lo_f_ff  <= pct_f ? sc_lo[hsvrgb_pkg::PctScaleShift +: CW]  : lo_e_ff;
         up_f_ff  <= pct_f ? sc_up[hsvrgb_pkg::PctScaleShift +: CW]  : up_e_ff;
         dn_f_ff  <= pct_f ? sc_dn[hsvrgb_pkg::PctScaleShift +: CW]  : dn_e_ff;
         val_f_ff <= pct_f ? sc_val[hsvrgb_pkg::PctScaleShift +: CW] : val_e_ff;
      end
   end

   assign ctl_out = ctl_ff[5];
   assign lo_out  = lo_f_ff;
   assign up_out  = up_f_ff;
   assign dn_out  = dn_f_ff;
   assign val_out = val_f_ff;

endmodule

/* sv/hsv_to_rgb_converter_core.sv */
// HSV to RGB pixel converter.
// req carries one pixel per request (hue, saturation, brightness); rsp returns
// red, green, blue and in_range. Both channels use valid/ready and a request
// moves on a clock edge where both are high.
// csr_we/csr_wdata write scale_mode: 0 = degrees and percent, 1 = byte scale.
// Write it only while no request is in flight; each request takes the mode
// that holds when it is accepted.
// Each result passes through the input register, six arithmetic stages and the
// output register before it is valid on rsp.
// Throughput: one request per cycle; no stage is shared between pixels, so
// the pipeline takes a new pixel on every clock while rsp is ready.
// When rsp stalls with a result waiting, the whole pipeline holds, empty
// slots included, and req.ready falls until the result is taken.
// Reset (synchronous) empties the pipeline and sets percent mode.
// A hue outside the mode's domain returns black with in_range low.
module hsv_to_rgb_converter_core (
   input  logic               clock,
   input  logic               reset,
   hsvrgb_req_if.sink         req,
   hsvrgb_rsp_if.source       rsp,
   input  logic               csr_we,
   input  logic               csr_wdata
);

   localparam int CW = hsvrgb_pkg::CompWidth;
   localparam int HW = hsvrgb_pkg::HueWidth;

   hsvrgb_pkg::mode_type scale_mode_ff;

   logic advance;

   // Decode
   logic [HW-1:0]       step_w;
   logic [2:0]          sext_cnt;
   logic [HW-1:0]       base;
   logic                range_ok;
   logic [CW-1:0]       sat_c, val_c;
   hsvrgb_pkg::ctl_type ctl_in;
   logic [8:0]          sat_inv_in;

   // Input register
   hsvrgb_pkg::ctl_type                ctl_s_ff;
   logic [hsvrgb_pkg::PosWidth-1:0]    pos_s_ff;
   logic [8:0]                         sat_inv_s_ff;
   logic [CW-1:0]                      val_s_ff;

   // Levels
   hsvrgb_pkg::ctl_type ctl_l;
   logic [CW-1:0]       lo_l, up_l, dn_l, val_l;

   // Output register
   logic          out_valid_ff;
   logic [CW-1:0] red_ff, green_ff, blue_ff;
   logic          in_range_ff;
   logic [CW-1:0] red_in, green_in, blue_in;

   // Pipeline moves unless a finished result waits
   assign advance   = !out_valid_ff || rsp.ready;
   assign req.ready = advance;

   // Mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_mode_ff <= hsvrgb_pkg::MODE_PERCENT;
      end else if (csr_we) begin
         scale_mode_ff <= hsvrgb_pkg::mode_type'(csr_wdata);
      end
   end

   // Sextant, clamp and range check
   always_comb begin
      if (scale_mode_ff == hsvrgb_pkg::MODE_BYTE) begin
         step_w   = HW'(hsvrgb_pkg::ByteSextant);
         range_ok = (req.hue < HW'(hsvrgb_pkg::ByteHueLimit));
         sat_c    = req.saturation;
         val_c    = req.brightness;
      end else begin
         step_w   = HW'(hsvrgb_pkg::PctSextant);
         range_ok = (req.hue < HW'(hsvrgb_pkg::PctHueLimit));
         sat_c    = (req.saturation > CW'(hsvrgb_pkg::PctMax))
                    ? CW'(hsvrgb_pkg::PctMax) : req.saturation;
         val_c    = (req.brightness > CW'(hsvrgb_pkg::PctMax))
                    ? CW'(hsvrgb_pkg::PctMax) : req.brightness;
      end
      sext_cnt = '0;
      for (int k = 1; k < hsvrgb_pkg::Sextants; k++) begin
         if (req.hue >= ((scale_mode_ff == hsvrgb_pkg::MODE_BYTE)
                         ? HW'(k * hsvrgb_pkg::ByteSextant)
                         : HW'(k * hsvrgb_pkg::PctSextant))) begin
            sext_cnt = sext_cnt + 3'd1;
         end
      end
      base = HW'(sext_cnt) * step_w;
      sat_inv_in = (scale_mode_ff == hsvrgb_pkg::MODE_BYTE)
                   ? 9'(9'(hsvrgb_pkg::ByteSatBase) - 9'(sat_c))
                   : 9'(9'(hsvrgb_pkg::PctMax) - 9'(sat_c));
      ctl_in.valid    = req.valid;
      ctl_in.in_range = range_ok;
      ctl_in.mode     = scale_mode_ff;
      ctl_in.sext     = hsvrgb_pkg::sext_type'(sext_cnt);
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_s_ff <= '0;
      end else if (advance) begin
         ctl_s_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pos_s_ff     <= hsvrgb_pkg::PosWidth'(req.hue - base);
         sat_inv_s_ff <= sat_inv_in;
         val_s_ff     <= val_c;
      end
   end

   hsvrgb_levels u_levels (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .ctl_in     (ctl_s_ff),
      .pos_in     (pos_s_ff),
      .sat_inv_in (sat_inv_s_ff),
      .val_in     (val_s_ff),
      .ctl_out    (ctl_l),
      .lo_out     (lo_l),
      .up_out     (up_l),
      .dn_out     (dn_l),
      .val_out    (val_l)
   );

   // Channel order by sextant; black when out of range
   always_comb begin
      case (ctl_l.sext)
         hsvrgb_pkg::SEXT_R_TO_Y: begin red_in = val_l; green_in = up_l;  blue_in = lo_l;  end
         hsvrgb_pkg::SEXT_Y_TO_G: begin red_in = dn_l;  green_in = val_l; blue_in = lo_l;  end
         hsvrgb_pkg::SEXT_G_TO_C: begin red_in = lo_l;  green_in = val_l; blue_in = up_l;  end
         hsvrgb_pkg::SEXT_C_TO_B: begin red_in = lo_l;  green_in = dn_l;  blue_in = val_l; end
         hsvrgb_pkg::SEXT_B_TO_M: begin red_in = up_l;  green_in = lo_l;  blue_in = val_l; end
         default:                 begin red_in = val_l; green_in = lo_l;  blue_in = dn_l;  end
      endcase
      if (!ctl_l.in_range) begin
         red_in   = '0;
         green_in = '0;
         blue_in  = '0;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= ctl_l.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         red_ff      <= red_in;
         green_ff    <= green_in;
         blue_ff     <= blue_in;
         in_range_ff <= ctl_l.in_range;
      end
   end

   assign rsp.valid    = out_valid_ff;
   assign rsp.red      = red_ff;
   assign rsp.green    = green_ff;
   assign rsp.blue     = blue_ff;
   assign rsp.in_range = in_range_ff;

endmodule

/* sv/hsvrgb_checker.sv */
`include "hsv_to_rgb_converter_core_defines.svh"

// Port-level checks on the converter.
module hsvrgb_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [hsvrgb_pkg::CompWidth-1:0] rsp_red,
   input logic [hsvrgb_pkg::CompWidth-1:0] rsp_green,
   input logic [hsvrgb_pkg::CompWidth-1:0] rsp_blue,
   input logic                             rsp_in_range
);

   // An out-of-range hue gives black
   `HSVRGB_ASSERT(a_black_out_of_range, (rsp_valid && !rsp_in_range) |-> (rsp_red == '0 && rsp_green == '0 && rsp_blue == '0), "out-of-range result not black")

   // A stalled result holds
   `HSVRGB_ASSERT(a_rsp_hold, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_red) && $stable(rsp_green) && $stable(rsp_blue) && $stable(rsp_in_range)), "stalled result changed")

   // Nothing comes out straight after reset
   `HSVRGB_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "result valid after reset")

   // An empty output slot never blocks a request
   `HSVRGB_ASSERT(a_ready_when_empty, (!rsp_valid || rsp_ready) |-> req_ready, "request blocked with free output")

   // After a request taken while the output is free, req stays ready next cycle unless a result is then valid
   `HSVRGB_ASSERT(a_ready_follows, (req_valid && req_ready && !rsp_valid) |=> (req_ready || rsp_valid), "pipeline stalled without a waiting result")

endmodule

bind hsv_to_rgb_converter_core hsvrgb_checker u_hsvrgb_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req.valid),
   .req_ready    (req.ready),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .rsp_red      (rsp.red),
   .rsp_green    (rsp.green),
   .rsp_blue     (rsp.blue),
   .rsp_in_range (rsp.in_range)
);

/* tb/sv/hsv_to_rgb_converter_core_tb.sv */
module hsv_to_rgb_converter_core_tb;

   localparam int HueW        = hsvrgb_pkg::HueWidth;
   localparam int CompW       = hsvrgb_pkg::CompWidth;
   localparam int FullScale   = 255;
   localparam int HoldCycles  = 80;
   localparam int DrainCycles = 20;
   localparam int HueTop      = (1 << HueW) - 1;

   typedef struct packed {
      logic [CompW-1:0] red;
      logic [CompW-1:0] green;
      logic [CompW-1:0] blue;
      logic             in_range;
   } rgb_pixel_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic csr_wdata;

   hsvrgb_req_if req_bus ();
   hsvrgb_rsp_if rsp_bus ();

   hsv_to_rgb_converter_core dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .rsp       (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // pixels accepted but not yet returned, oldest first
   rgb_pixel_type        expected_pixels[$];
   hsvrgb_pkg::mode_type active_mode;

   int mismatches        = 0;
   int unexpected_pixels = 0;
   int pct_pixels        = 0;
   int byte_pixels       = 0;
   int dark_pixels       = 0;
   int mode_writes       = 0;
   int long_holds        = 0;

   // sender burst control, owned by the stimulus thread
   int burst_left = 0;
   bit gaps_on    = 1'b1;

   // long hold-off: stimulus bumps hold_count, receiver counts the stretch
   int hold_count = 0;
   int hold_seen  = 0;
   int hold_left  = 0;
   int stall_pct  = 0;
   int stall_left = 0;

   // 10 time unit clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Expected RGB for one pixel under the given scale mode
   function automatic rgb_pixel_type convert_pixel(input hsvrgb_pkg::mode_type mode,
                                                   input logic [HueW-1:0] hue,
                                                   input logic [CompW-1:0] sat,
                                                   input logic [CompW-1:0] bri);
      int unsigned          s, v, lo, step, up, dn, pos;
      hsvrgb_pkg::sext_type sext;
      rgb_pixel_type        px;
      px = '0;
      s  = sat;
      v  = bri;
      if (mode == hsvrgb_pkg::MODE_PERCENT) begin
         if (hue >= hsvrgb_pkg::PctHueLimit) return px;
         if (s > hsvrgb_pkg::PctMax) s = hsvrgb_pkg::PctMax;
         if (v > hsvrgb_pkg::PctMax) v = hsvrgb_pkg::PctMax;
         sext = hsvrgb_pkg::sext_type'(hue / hsvrgb_pkg::PctSextant);
         pos  = hue % hsvrgb_pkg::PctSextant;
         lo   = ((hsvrgb_pkg::PctMax - s) * v) / hsvrgb_pkg::PctMax;
         step = ((v - lo) * pos) / hsvrgb_pkg::PctSextant;
         up   = lo + step;
         dn   = v - step;
         // rescale percent levels to bytes
         lo   = (lo * FullScale) / hsvrgb_pkg::PctMax;
         up   = (up * FullScale) / hsvrgb_pkg::PctMax;
         dn   = (dn * FullScale) / hsvrgb_pkg::PctMax;
         v    = (v * FullScale) / hsvrgb_pkg::PctMax;
      end else begin
         if (hue >= hsvrgb_pkg::ByteHueLimit) return px;
         sext = hsvrgb_pkg::sext_type'(hue / hsvrgb_pkg::ByteSextant);
         pos  = hue % hsvrgb_pkg::ByteSextant;
         lo   = ((hsvrgb_pkg::ByteSatBase - s) * v) / hsvrgb_pkg::ByteSatBase;
         step = ((v - lo) * pos) / hsvrgb_pkg::ByteSextant;
         up   = lo + step;
         dn   = v - step;
      end
      px.in_range = 1'b1;
      // sextant picks the channel order
      case (sext)
         hsvrgb_pkg::SEXT_R_TO_Y: begin
            px.red = CompW'(v);  px.green = CompW'(up); px.blue = CompW'(lo);
         end
         hsvrgb_pkg::SEXT_Y_TO_G: begin
            px.red = CompW'(dn); px.green = CompW'(v);  px.blue = CompW'(lo);
         end
         hsvrgb_pkg::SEXT_G_TO_C: begin
            px.red = CompW'(lo); px.green = CompW'(v);  px.blue = CompW'(up);
         end
         hsvrgb_pkg::SEXT_C_TO_B: begin
            px.red = CompW'(lo); px.green = CompW'(dn); px.blue = CompW'(v);
         end
         hsvrgb_pkg::SEXT_B_TO_M: begin
            px.red = CompW'(up); px.green = CompW'(lo); px.blue = CompW'(v);
         end
         default: begin
            px.red = CompW'(v);  px.green = CompW'(lo); px.blue = CompW'(dn);
         end
      endcase
      return px;
   endfunction

   task automatic check_field(input string name, input logic [CompW-1:0] want,
                              input logic [CompW-1:0] got);
      if (got !== want) begin
         mismatches++;
         $error("%s: expected %0d, got %0d", name, want, got);
      end
   endtask

   // Scoreboard: check returned pixels, predict accepted requests, track the mode
   always @(posedge clock) begin : scoreboard
      rgb_pixel_type want;
      if (reset) begin
         active_mode = hsvrgb_pkg::MODE_PERCENT;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_pixels.size() == 0) begin
               unexpected_pixels++;
               $error("pixel returned with no request outstanding");
            end else begin
               want = expected_pixels.pop_front();
               check_field("red", want.red, rsp_bus.red);
               check_field("green", want.green, rsp_bus.green);
               check_field("blue", want.blue, rsp_bus.blue);
               check_field("in_range", CompW'(want.in_range), CompW'(rsp_bus.in_range));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            want = convert_pixel(active_mode, req_bus.hue, req_bus.saturation,
                                 req_bus.brightness);
            expected_pixels.push_back(want);
            if (active_mode == hsvrgb_pkg::MODE_PERCENT) pct_pixels++;
            else byte_pixels++;
            if (!want.in_range) dark_pixels++;
         end
         if (csr_we) begin
            active_mode = hsvrgb_pkg::mode_type'(csr_wdata);
            mode_writes++;
         end
      end
   end

   // Receiver: stall level changes in phases, plus the occasional long hold-off
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_count != hold_seen) begin
            hold_seen = hold_count;
            hold_left = HoldCycles;
            long_holds++;
         end
         if (stall_left == 0) begin
            case ($urandom_range(0, 4))
               0:       stall_pct = 0;
               1:       stall_pct = 10;
               2:       stall_pct = 30;
               3:       stall_pct = 60;
               default: stall_pct = 90;
            endcase
            stall_left = $urandom_range(20, 150);
         end else begin
            stall_left--;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(1, 100) > stall_pct);
         end
      end
   end

   // Offer one request and wait for it to be taken; gaps fall between bursts
   task automatic send_pixel(input logic [HueW-1:0] hue, input logic [CompW-1:0] sat,
                             input logic [CompW-1:0] bri);
      if (gaps_on) begin
         if (burst_left == 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            burst_left = $urandom_range(1, 30);
         end else begin
            burst_left--;
         end
      end
      req_bus.valid      <= 1'b1;
      req_bus.hue        <= hue;
      req_bus.saturation <= sat;
      req_bus.brightness <= bri;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic drain_pixels();
      req_bus.valid <= 1'b0;
      // one edge first so a request taken on this edge is already queued
      @(posedge clock);
      while (expected_pixels.size() != 0) @(posedge clock);
   endtask

   // Mode register is only written with the pipeline empty
   task automatic set_scale_mode(input hsvrgb_pkg::mode_type mode);
      drain_pixels();
      csr_we    <= 1'b1;
      csr_wdata <= mode;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [HueW-1:0] rand_hue(input int limit, input int span);
      case ($urandom_range(0, 9))
         0:       return HueW'($urandom_range(limit, HueTop));
         1:       return HueW'($urandom_range(1, hsvrgb_pkg::Sextants - 1) * span
                               - $urandom_range(0, 1));
         default: return HueW'($urandom_range(0, limit - 1));
      endcase
   endfunction

   function automatic logic [CompW-1:0] rand_level(input int limit);
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return CompW'(limit);
         2:       return CompW'($urandom_range(0, FullScale));
         default: return CompW'($urandom_range(0, limit));
      endcase
   endfunction

   task automatic run_random_pixels(input hsvrgb_pkg::mode_type mode, input int count);
      int hue_limit, span, level_limit;
      hue_limit   = (mode == hsvrgb_pkg::MODE_PERCENT) ? hsvrgb_pkg::PctHueLimit
                                                       : hsvrgb_pkg::ByteHueLimit;
      span        = (mode == hsvrgb_pkg::MODE_PERCENT) ? hsvrgb_pkg::PctSextant
                                                       : hsvrgb_pkg::ByteSextant;
      level_limit = (mode == hsvrgb_pkg::MODE_PERCENT) ? hsvrgb_pkg::PctMax : FullScale;
      repeat (count)
         send_pixel(rand_hue(hue_limit, span), rand_level(level_limit), rand_level(level_limit));
   endtask

   // Sextant edges, grey and black, clamping above 100, hue out of domain
   task automatic test_percent_directed();
      set_scale_mode(hsvrgb_pkg::MODE_PERCENT);
      send_pixel(0, 100, 100);
      send_pixel(60, 100, 100);
      send_pixel(120, 100, 100);
      send_pixel(180, 100, 100);
      send_pixel(240, 100, 100);
      send_pixel(300, 100, 100);
      send_pixel(359, 255, 255);
      send_pixel(59, 50, 80);
      send_pixel(30, 0, 100);
      send_pixel(90, 100, 0);
      send_pixel(200, 101, 101);
      send_pixel(360, 50, 50);
      send_pixel(HueW'(HueTop), 255, 255);
   endtask

   task automatic test_byte_directed();
      set_scale_mode(hsvrgb_pkg::MODE_BYTE);
      send_pixel(0, 255, 255);
      send_pixel(42, 255, 255);
      send_pixel(43, 255, 255);
      send_pixel(86, 255, 255);
      send_pixel(129, 255, 255);
      send_pixel(172, 255, 255);
      send_pixel(215, 255, 255);
      send_pixel(255, 128, 200);
      send_pixel(100, 0, 255);
      send_pixel(10, 255, 0);
      send_pixel(256, 255, 255);
      send_pixel(HueW'(HueTop), 0, 0);
   endtask

   task automatic test_byte_random();
      run_random_pixels(hsvrgb_pkg::MODE_BYTE, 250);
   endtask

   task automatic test_percent_random();
      set_scale_mode(hsvrgb_pkg::MODE_PERCENT);
      run_random_pixels(hsvrgb_pkg::MODE_PERCENT, 250);
   endtask

   // Alternate the mode between short bursts of pixels
   task automatic test_mode_switching();
      hsvrgb_pkg::mode_type mode;
      for (int i = 0; i < 6; i++) begin
         mode = (i % 2 == 0) ? hsvrgb_pkg::MODE_BYTE : hsvrgb_pkg::MODE_PERCENT;
         set_scale_mode(mode);
         run_random_pixels(mode, 20);
      end
   endtask

   // Hold the output off while requests keep coming, so the pipe fills and stalls req
   task automatic test_output_backpressure();
      hold_count <= hold_count + 1;
      gaps_on = 1'b0;
      run_random_pixels(hsvrgb_pkg::MODE_PERCENT, 40);
      gaps_on = 1'b1;
   endtask

   initial begin
      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_wdata          <= 1'b0;
      req_bus.valid      <= 1'b0;
      req_bus.hue        <= '0;
      req_bus.saturation <= '0;
      req_bus.brightness <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_percent_directed();
      test_byte_directed();
      test_byte_random();
      test_percent_random();
      test_mode_switching();
      test_output_backpressure();

      drain_pixels();
      repeat (DrainCycles) @(posedge clock);

      $display("Covered %0d pixels: %0d percent mode, %0d byte mode, %0d with hue out of range.",
               pct_pixels + byte_pixels, pct_pixels, byte_pixels, dark_pixels);
      $display("Mode writes %0d, long output hold-offs %0d, mismatches %0d, unexpected %0d.",
               mode_writes, long_holds, mismatches, unexpected_pixels);
      if (mismatches == 0 && unexpected_pixels == 0 && expected_pixels.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // Run limit
   initial begin
      #2000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
